[hdl/sql_wire_packet_deframer_unit_macros.svh]
// assertion macros for the packet deframer
// used by the queue and the back stage; expects clk and rst_n in scope
`ifndef SQL_WIRE_PACKET_DEFRAMER_UNIT_MACROS_SVH
`define SQL_WIRE_PACKET_DEFRAMER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// property checked while out of reset
`define SWPD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked while out of reset
`define SWPD_ASSERT_IMP(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) else $error(msg);

`else

`define SWPD_ASSERT(lbl, prop, msg)
`define SWPD_ASSERT_IMP(lbl, cond, prop, msg)

`endif

`endif

[hdl/swpd_pkg.sv]
// shared types and constants for the packet deframer
// no dependencies
`timescale 1ns / 1ps

package swpd_pkg;

    // header is three length bytes and one sequence byte
    localparam logic [2:0] HDR_BYTES = 3'd4;

    // saturation point of the group packet count
    localparam logic [15:0] CNT_MAX = 16'hFFFF;

    // register reset value
    localparam logic [7:0] QUERY_OPCODE_RST = 8'h03;

    // default depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // result kinds
    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_EVENT   = 2'd2;

    // item class decided at the front
    typedef enum logic
    {
        ITEM_BYTE  = 1'b0,
        ITEM_EVENT = 1'b1
    } item_class_t;

    // classified word carried through the queue
    typedef struct packed
    {
        item_class_t cls;
        logic [7:0]  data;
    } swpd_item_t;

endpackage

[hdl/swpd_front.sv]
// front stage: accepts input words, classifies them, holds them in a register
// depends on swpd_pkg
`timescale 1ns / 1ps

module swpd_front
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 op,
    input  logic [7:0]           data_byte,
    output logic                 push_valid,
    input  logic                 push_ready,
    output swpd_pkg::swpd_item_t push_item
);
    import swpd_pkg::*;

    logic       stage_valid_reg;
    logic       stage_valid_next;
    swpd_item_t stage_item_reg;
    swpd_item_t stage_item_next;
    logic       in_take;

    // the stage frees whenever its word moves on
    assign in_ready = !stage_valid_reg || push_ready;
    assign in_take  = in_valid && in_ready;

    // classify the incoming word
    always_comb
    begin
        stage_item_next = stage_item_reg;
        if (in_take)
        begin
            if (op)
            begin
                stage_item_next.cls  = ITEM_EVENT;
                stage_item_next.data = 8'd0;
            end
            else
            begin
                stage_item_next.cls  = ITEM_BYTE;
                stage_item_next.data = data_byte;
            end
        end
        stage_valid_next = in_take || (stage_valid_reg && !push_ready);
    end

    // stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        stage_item_reg <= stage_item_next;
    end

    assign push_valid = stage_valid_reg;
    assign push_item  = stage_item_reg;

endmodule

[hdl/swpd_queue.sv]
// short queue of classified words between front and back
// depends on swpd_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "sql_wire_packet_deframer_unit_macros.svh"

module swpd_queue
#(
    parameter int Depth = swpd_pkg::QUEUE_DEPTH
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push_valid,
    output logic                 push_ready,
    input  swpd_pkg::swpd_item_t push_item,
    output logic                 pop_valid,
    input  logic                 pop_ready,
    output swpd_pkg::swpd_item_t pop_item
);
    import swpd_pkg::*;

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);
    localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
    localparam logic [CntW-1:0] CntFull = CntW'(Depth);

    swpd_item_t      entry_reg [Depth];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [PtrW-1:0] rd_ptr_next;
    logic [CntW-1:0] count_reg;
    logic [CntW-1:0] count_next;
    logic            push;
    logic            pop;

    assign push_ready = (count_reg != CntFull);
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_item   = entry_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrLast) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrLast) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    // fill count stays within depth
    `SWPD_ASSERT(a_count_bound, count_reg <= CntFull, "queue count beyond depth")
    // pointers agree with the count when empty
    `SWPD_ASSERT_IMP(a_empty_ptrs, count_reg == '0, rd_ptr_reg == wr_ptr_reg,
        "queue pointers differ while empty")
    // a pop without a push lowers the count by one
    `SWPD_ASSERT_IMP(a_pop_count, pop && !push, ##1 count_reg == $past(count_reg) - 1'b1,
        "queue count not lowered on pop")

endmodule

[hdl/swpd_back.sv]
// back stage: packet framing and grouping state, output register; one word per
// cycle unless the output stalls; depends on swpd_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "sql_wire_packet_deframer_unit_macros.svh"

module swpd_back
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_write_en,
    input  logic [7:0]           cfg_write_data,
    input  logic                 pop_valid,
    output logic                 pop_ready,
    input  swpd_pkg::swpd_item_t pop_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [1:0]           kind,
    output logic [7:0]           out_byte,
    output logic [23:0]          packet_length,
    output logic [7:0]           sequence_id,
    output logic [23:0]          payload_index,
    output logic                 packet_end,
    output logic                 command_text,
    output logic                 group_closed,
    output logic [15:0]          closed_packets,
    output logic                 closed_was_query
);
    import swpd_pkg::*;

    logic [7:0]  query_opcode_reg;

    // framing and grouping state
    logic [2:0]  header_count_reg;
    logic [2:0]  header_count_next;
    logic [23:0] length_accum_reg;
    logic [23:0] length_accum_next;
    logic [7:0]  current_sequence_reg;
    logic [7:0]  current_sequence_next;
    logic [23:0] payload_seen_reg;
    logic [23:0] payload_seen_next;
    logic [7:0]  previous_sequence_reg;
    logic [7:0]  previous_sequence_next;
    logic [15:0] group_packets_reg;
    logic [15:0] group_packets_next;
    logic        group_is_query_reg;
    logic        group_is_query_next;
    logic        current_is_query_reg;
    logic        current_is_query_next;
    logic        complete_reg;
    logic        complete_next;

    // output register
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [1:0]  kind_reg;
    logic [1:0]  kind_next;
    logic [7:0]  out_byte_reg;
    logic [7:0]  out_byte_next;
    logic [23:0] packet_length_reg;
    logic [23:0] packet_length_next;
    logic [7:0]  sequence_id_reg;
    logic [7:0]  sequence_id_next;
    logic [23:0] payload_index_reg;
    logic [23:0] payload_index_next;
    logic        packet_end_reg;
    logic        packet_end_next;
    logic        command_text_reg;
    logic        command_text_next;
    logic        group_closed_reg;
    logic        group_closed_next;
    logic [15:0] closed_packets_reg;
    logic [15:0] closed_packets_next;
    logic        closed_was_query_reg;
    logic        closed_was_query_next;

    logic        pop;
    logic        opcode_match;

    assign pop_ready    = !out_valid_reg || out_ready;
    assign pop          = pop_valid && pop_ready;
    assign opcode_match = (pop_item.data == query_opcode_reg);

    // one word of framing work
    always_comb
    begin
        header_count_next      = header_count_reg;
        length_accum_next      = length_accum_reg;
        current_sequence_next  = current_sequence_reg;
        payload_seen_next      = payload_seen_reg;
        previous_sequence_next = previous_sequence_reg;
        group_packets_next     = group_packets_reg;
        group_is_query_next    = group_is_query_reg;
        current_is_query_next  = current_is_query_reg;
        complete_next          = complete_reg;

        kind_next             = KIND_EVENT;
        out_byte_next         = 8'd0;
        packet_length_next    = 24'd0;
        sequence_id_next      = 8'd0;
        payload_index_next    = 24'd0;
        packet_end_next       = 1'b0;
        command_text_next     = 1'b0;
        group_closed_next     = 1'b0;
        closed_packets_next   = 16'd0;
        closed_was_query_next = 1'b0;

        if (pop_item.cls == ITEM_EVENT)
        begin
            // server event closes what is finished
            if (group_packets_reg != 16'd0)
            begin
                if (!complete_reg)
                begin
                    if (group_packets_reg != 16'd1)
                    begin
                        group_closed_next     = 1'b1;
                        closed_packets_next   = group_packets_reg - 16'd1;
                        closed_was_query_next = group_is_query_reg;
                    end
                    group_packets_next  = 16'd1;
                    group_is_query_next = current_is_query_reg;
                end
                else
                begin
                    group_closed_next     = 1'b1;
                    closed_packets_next   = group_packets_reg;
                    closed_was_query_next = group_is_query_reg;
                    group_packets_next    = 16'd0;
                    group_is_query_next   = 1'b0;
                end
            end
        end
        else
        begin
            out_byte_next = pop_item.data;

            // start of a new packet
            if (group_packets_reg == 16'd0 || complete_reg)
            begin
                if (group_packets_reg != 16'd0)
                begin
                    previous_sequence_next = current_sequence_reg;
                end
                if (group_packets_reg != CNT_MAX)
                begin
                    group_packets_next = group_packets_reg + 16'd1;
                end
                header_count_next     = 3'd0;
                length_accum_next     = 24'd0;
                payload_seen_next     = 24'd0;
                current_is_query_next = 1'b0;
                complete_next         = 1'b0;
            end

            if (header_count_next != HDR_BYTES)
            begin
                // header byte
                kind_next = KIND_HEADER;
                case (header_count_next[1:0])
                    2'd0:
                    begin
                        length_accum_next[7:0] = pop_item.data;
                        header_count_next      = 3'd1;
                    end
                    2'd1:
                    begin
                        length_accum_next[15:8] = pop_item.data;
                        header_count_next       = 3'd2;
                    end
                    2'd2:
                    begin
                        length_accum_next[23:16] = pop_item.data;
                        header_count_next        = 3'd3;
                    end
                    default:
                    begin
                        current_sequence_next = pop_item.data;
                        header_count_next     = HDR_BYTES;
                        packet_length_next    = length_accum_next;
                        sequence_id_next      = pop_item.data;
                        packet_end_next       = (length_accum_next == 24'd0);
                        complete_next         = (length_accum_next == 24'd0);
                        // chain check against the previous packet
                        if (group_packets_next > 16'd1 &&
                            pop_item.data != previous_sequence_next + 8'd1)
                        begin
                            group_closed_next     = 1'b1;
                            closed_packets_next   = group_packets_next - 16'd1;
                            closed_was_query_next = group_is_query_next;
                            group_packets_next    = 16'd1;
                            group_is_query_next   = 1'b0;
                        end
                    end
                endcase
            end
            else
            begin
                // payload byte
                kind_next          = KIND_PAYLOAD;
                packet_length_next = length_accum_reg;
                sequence_id_next   = current_sequence_reg;
                payload_index_next = payload_seen_reg;
                if (payload_seen_reg == 24'd0)
                begin
                    current_is_query_next = opcode_match;
                    if (group_packets_reg == 16'd1)
                    begin
                        group_is_query_next = opcode_match;
                    end
                end
                else if (group_is_query_reg)
                begin
                    command_text_next = 1'b1;
                end
                payload_seen_next = payload_seen_reg + 24'd1;
                packet_end_next   = (payload_seen_next == length_accum_reg);
                complete_next     = (payload_seen_next == length_accum_reg);
            end
        end

        out_valid_next = pop || (out_valid_reg && !out_ready);
    end

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            query_opcode_reg <= QUERY_OPCODE_RST;
        end
        else if (cfg_write_en)
        begin
            query_opcode_reg <= cfg_write_data;
        end
    end

    // framing state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_count_reg      <= 3'd0;
            length_accum_reg      <= 24'd0;
            current_sequence_reg  <= 8'd0;
            payload_seen_reg      <= 24'd0;
            previous_sequence_reg <= 8'd0;
            group_packets_reg     <= 16'd0;
            group_is_query_reg    <= 1'b0;
            current_is_query_reg  <= 1'b0;
            complete_reg          <= 1'b0;
            out_valid_reg         <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                header_count_reg      <= header_count_next;
                length_accum_reg      <= length_accum_next;
                current_sequence_reg  <= current_sequence_next;
                payload_seen_reg      <= payload_seen_next;
                previous_sequence_reg <= previous_sequence_next;
                group_packets_reg     <= group_packets_next;
                group_is_query_reg    <= group_is_query_next;
                current_is_query_reg  <= current_is_query_next;
                complete_reg          <= complete_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            kind_reg             <= kind_next;
            out_byte_reg         <= out_byte_next;
            packet_length_reg    <= packet_length_next;
            sequence_id_reg      <= sequence_id_next;
            payload_index_reg    <= payload_index_next;
            packet_end_reg       <= packet_end_next;
            command_text_reg     <= command_text_next;
            group_closed_reg     <= group_closed_next;
            closed_packets_reg   <= closed_packets_next;
            closed_was_query_reg <= closed_was_query_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign kind             = kind_reg;
    assign out_byte         = out_byte_reg;
    assign packet_length    = packet_length_reg;
    assign sequence_id      = sequence_id_reg;
    assign payload_index    = payload_index_reg;
    assign packet_end       = packet_end_reg;
    assign command_text     = command_text_reg;
    assign group_closed     = group_closed_reg;
    assign closed_packets   = closed_packets_reg;
    assign closed_was_query = closed_was_query_reg;

    // a finished packet always has its full header
    `SWPD_ASSERT_IMP(a_complete_hdr, complete_reg, header_count_reg == HDR_BYTES,
        "packet marked complete before its header")
    // no closed count without a closed group
    `SWPD_ASSERT_IMP(a_close_count, out_valid_reg && !group_closed_reg,
        closed_packets_reg == 16'd0 && !closed_was_query_reg,
        "closed group fields set with no group closing")
    // command text only on payload words past the opcode
    `SWPD_ASSERT_IMP(a_cmd_text, out_valid_reg && command_text_reg,
        kind_reg == KIND_PAYLOAD && payload_index_reg != 24'd0,
        "command text flagged outside payload")

endmodule

[hdl/sql_wire_packet_deframer_unit.sv]
// top level of the packet deframer: front stage, word queue, back stage
// depends on swpd_pkg, swpd_front, swpd_queue and swpd_back
`timescale 1ns / 1ps

// Takes one word per clock when not stalled: a client stream byte or a server
// event. Each word gives exactly one result word, tagged as header byte, payload
// byte or event, with its packet length, sequence byte, payload index and end
// of packet, plus the group close report. Sustained rate is one word per cycle
// while the output is not stalled, set by the back stage state update; a word
// passes the front register, a queue entry and the output register in order
// before its result is valid.
// The queue of QueueDepth words lets the front keep accepting while the result
// register waits. The query opcode register may be written only while idle.
module sql_wire_packet_deframer_unit
#(
    parameter int QueueDepth = swpd_pkg::QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic [7:0]  cfg_write_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        op,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [7:0]  out_byte,
    output logic [23:0] packet_length,
    output logic [7:0]  sequence_id,
    output logic [23:0] payload_index,
    output logic        packet_end,
    output logic        command_text,
    output logic        group_closed,
    output logic [15:0] closed_packets,
    output logic        closed_was_query
);
    import swpd_pkg::*;

    logic       push_valid;
    logic       push_ready;
    swpd_item_t push_item;
    logic       pop_valid;
    logic       pop_ready;
    swpd_item_t pop_item;

    // accept and classify
    swpd_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .op         (op),
        .data_byte  (data_byte),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    // decoupling queue
    swpd_queue
    #(
        .Depth (QueueDepth)
    )
    u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    // framing and grouping
    swpd_back u_back
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_en     (cfg_write_en),
        .cfg_write_data   (cfg_write_data),
        .pop_valid        (pop_valid),
        .pop_ready        (pop_ready),
        .pop_item         (pop_item),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .kind             (kind),
        .out_byte         (out_byte),
        .packet_length    (packet_length),
        .sequence_id      (sequence_id),
        .payload_index    (payload_index),
        .packet_end       (packet_end),
        .command_text     (command_text),
        .group_closed     (group_closed),
        .closed_packets   (closed_packets),
        .closed_was_query (closed_was_query)
    );

endmodule
